/* rtl/sdww_pkg.sv */
// Package with geometry constants, command opcodes and types of the display window writer.
package sdww_pkg;

	localparam int unsigned DisplayHeight = 160;
	localparam int unsigned BytesPerPixel = 2;
	localparam int unsigned RowStride     = 256;

	localparam int unsigned MemBytes = DisplayHeight * RowStride;
	localparam int unsigned AddrFullW = 30;
	localparam int unsigned MemAddrW  = 16;

	localparam logic [7:0] OP_COLSET = 8'h2A;
	localparam logic [7:0] OP_ROWSET = 8'h2B;
	localparam logic [7:0] OP_MEMWR  = 8'h2C;
	localparam logic [7:0] OP_DISPON = 8'h29;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_COLSET = 2'd1,
		CMD_ROWSET = 2'd2,
		CMD_MEMWR  = 2'd3
	} cmd_t;

endpackage

/* rtl/spi_display_window_writer_top.sv */
// Top level of the display window writer: command decode, window registers and pixel addressing.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------------
//  in      | input     | in_valid, in_stall | data_byte, is_data, chip_select_n
//  out     | output    | out_valid,         | mem_write, mem_addr, mem_data, changed,
//          |           | out_stall          | out_of_range, display_on
//
// Every input transaction yields exactly one output transaction, presented from the result register.
// A new transaction is taken in every cycle while the result register is empty or being drained.
// The result register is the only stage, so in_stall is high only while a result waits on out_stall.
// Reset clears the window, cursor, command and display-on state to zero.
module spi_display_window_writer_top
	import sdww_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        is_data,
	input  logic        chip_select_n,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        mem_write,
	output logic [15:0] mem_addr,
	output logic [7:0]  mem_data,
	output logic        changed,
	output logic        out_of_range,
	output logic        display_on
);

	cmd_t        active_command_q, active_command_d;
	logic [2:0]  byte_count_q, byte_count_d;
	logic [7:0]  staged_q [3];
	logic [15:0] col_start_q, col_start_d;
	logic [15:0] col_end_excl_q, col_end_excl_d;
	logic [15:0] row_start_q, row_start_d;
	logic [15:0] row_end_excl_q, row_end_excl_d;
	logic [15:0] cursor_col_q, cursor_col_d;
	logic [15:0] cursor_row_q, cursor_row_d;
	logic        display_enabled_q, display_enabled_d;
	logic        stage_en;

	logic        wr_d, changed_d, oor_d;
	logic [AddrFullW-1:0] addr_full;
	logic [15:0] win_start, win_end_excl, col_inc, row_inc;
	logic        accept;

	logic        out_valid_q;
	logic        mem_write_q, changed_q, out_of_range_q, display_on_q;
	logic [15:0] mem_addr_q;
	logic [7:0]  mem_data_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign win_start    = {staged_q[0], staged_q[1]};
	assign win_end_excl = {staged_q[2], data_byte} + 16'd1;
	assign col_inc      = cursor_col_q + 16'd1;
	assign row_inc      = cursor_row_q + 16'd1;
	assign addr_full    = AddrFullW'(cursor_row_q) * AddrFullW'(RowStride)
	                    + AddrFullW'(cursor_col_q) * AddrFullW'(BytesPerPixel)
	                    + AddrFullW'(byte_count_q[0]);

	always_comb begin
		active_command_d  = active_command_q;
		byte_count_d      = byte_count_q;
		col_start_d       = col_start_q;
		col_end_excl_d    = col_end_excl_q;
		row_start_d       = row_start_q;
		row_end_excl_d    = row_end_excl_q;
		cursor_col_d      = cursor_col_q;
		cursor_row_d      = cursor_row_q;
		display_enabled_d = display_enabled_q;
		stage_en          = 1'b0;
		wr_d              = 1'b0;
		changed_d         = 1'b0;
		oor_d             = 1'b0;
		if (!chip_select_n) begin
			if (!is_data) begin
				unique case (data_byte)
					OP_COLSET: begin
						active_command_d = CMD_COLSET;
						byte_count_d     = 3'd0;
					end
					OP_ROWSET: begin
						active_command_d = CMD_ROWSET;
						byte_count_d     = 3'd0;
					end
					OP_MEMWR: begin
						active_command_d = CMD_MEMWR;
						byte_count_d     = 3'd0;
					end
					OP_DISPON: begin
						display_enabled_d = 1'b1;
					end
					default: begin
					end
				endcase
			end else if (active_command_q == CMD_COLSET || active_command_q == CMD_ROWSET) begin
				if (byte_count_q < 3'd3) begin
					stage_en     = 1'b1;
					byte_count_d = byte_count_q + 3'd1;
				end else begin
					if (active_command_q == CMD_COLSET) begin
						col_start_d    = win_start;
						col_end_excl_d = win_end_excl;
						cursor_col_d   = win_start;
					end else begin
						row_start_d    = win_start;
						row_end_excl_d = win_end_excl;
						cursor_row_d   = win_start;
					end
					active_command_d = CMD_NONE;
					byte_count_d     = 3'd0;
					changed_d        = 1'b1;
				end
			end else if (active_command_q == CMD_MEMWR) begin
				if (addr_full >= AddrFullW'(MemBytes)) begin
					oor_d = 1'b1;
				end else begin
					wr_d      = 1'b1;
					changed_d = 1'b1;
				end
				byte_count_d = byte_count_q + 3'd1;
				if (byte_count_q[0]) begin
					cursor_col_d = col_inc;
					if (col_inc >= col_end_excl_q) begin
						cursor_col_d = col_start_q;
						cursor_row_d = row_inc;
						if (row_inc >= row_end_excl_q) begin
							cursor_row_d = row_start_q;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_command_q  <= CMD_NONE;
			byte_count_q      <= 3'd0;
			staged_q[0]       <= 8'd0;
			staged_q[1]       <= 8'd0;
			staged_q[2]       <= 8'd0;
			col_start_q       <= 16'd0;
			col_end_excl_q    <= 16'd0;
			row_start_q       <= 16'd0;
			row_end_excl_q    <= 16'd0;
			cursor_col_q      <= 16'd0;
			cursor_row_q      <= 16'd0;
			display_enabled_q <= 1'b0;
		end else if (accept) begin
			active_command_q  <= active_command_d;
			byte_count_q      <= byte_count_d;
			if (stage_en) begin
				staged_q[byte_count_q[1:0]] <= data_byte;
			end
			col_start_q       <= col_start_d;
			col_end_excl_q    <= col_end_excl_d;
			row_start_q       <= row_start_d;
			row_end_excl_q    <= row_end_excl_d;
			cursor_col_q      <= cursor_col_d;
			cursor_row_q      <= cursor_row_d;
			display_enabled_q <= display_enabled_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_write_q    <= wr_d;
			mem_addr_q     <= wr_d ? addr_full[MemAddrW-1:0] : 16'd0;
			mem_data_q     <= wr_d ? data_byte : 8'd0;
			changed_q      <= changed_d;
			out_of_range_q <= oor_d;
			display_on_q   <= display_enabled_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign mem_write    = mem_write_q;
	assign mem_addr     = mem_addr_q;
	assign mem_data     = mem_data_q;
	assign changed      = changed_q;
	assign out_of_range = out_of_range_q;
	assign display_on   = display_on_q;

endmodule

/* tb/frame_write_checker.sv */
// Checker that predicts and compares every frame memory write result of the window writer.
module frame_write_checker
	import sdww_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        is_data,
	input  logic        chip_select_n,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        mem_write,
	input  logic [15:0] mem_addr,
	input  logic [7:0]  mem_data,
	input  logic        changed,
	input  logic        out_of_range,
	input  logic        display_on,
	output int unsigned mismatch_count,
	output int unsigned results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        chg;
		logic        oor;
		logic        disp;
	} frame_write_t;

	cmd_t         cur_cmd;
	logic [2:0]   param_cnt;
	logic [7:0]   param_bytes [3];
	logic [15:0]  col_lo;
	logic [15:0]  col_hi_excl;
	logic [15:0]  row_lo;
	logic [15:0]  row_hi_excl;
	logic [15:0]  cur_col;
	logic [15:0]  cur_row;
	logic         disp_flag;
	frame_write_t expected_writes [$];
	frame_write_t seen_write;
	frame_write_t due_write;
	int unsigned  mismatch_total = 0;

	assign mismatch_count = mismatch_total;

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatch_total++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	function automatic frame_write_t decode_spi_byte(logic [7:0] b, logic dc, logic csn);
		frame_write_t res;
		logic [15:0]  lo;
		logic [15:0]  hi;
		int unsigned  addr;
		logic         parity;
		res = '0;
		if (!csn) begin
			if (!dc) begin
				case (b)
					OP_COLSET: begin
						cur_cmd = CMD_COLSET;
						param_cnt = '0;
					end
					OP_ROWSET: begin
						cur_cmd = CMD_ROWSET;
						param_cnt = '0;
					end
					OP_MEMWR: begin
						cur_cmd = CMD_MEMWR;
						param_cnt = '0;
					end
					OP_DISPON: disp_flag = 1'b1;
					default: ;
				endcase
			end else if (cur_cmd == CMD_COLSET || cur_cmd == CMD_ROWSET) begin
				if (param_cnt < 3'd3) begin
					param_bytes[param_cnt[1:0]] = b;
					param_cnt = param_cnt + 3'd1;
				end else begin
					lo = {param_bytes[0], param_bytes[1]};
					hi = {param_bytes[2], b} + 16'd1;
					if (cur_cmd == CMD_COLSET) begin
						col_lo = lo;
						col_hi_excl = hi;
						cur_col = lo;
					end else begin
						row_lo = lo;
						row_hi_excl = hi;
						cur_row = lo;
					end
					cur_cmd = CMD_NONE;
					param_cnt = '0;
					res.chg = 1'b1;
				end
			end else if (cur_cmd == CMD_MEMWR) begin
				parity = param_cnt[0];
				addr = cur_row * RowStride + cur_col * BytesPerPixel + parity;
				if (addr >= MemBytes) begin
					res.oor = 1'b1;
				end else begin
					res.wr = 1'b1;
					res.addr = addr[15:0];
					res.data = b;
					res.chg = 1'b1;
				end
				param_cnt = param_cnt + 3'd1;
				if (parity) begin
					cur_col = cur_col + 16'd1;
					if (cur_col >= col_hi_excl) begin
						cur_col = col_lo;
						cur_row = cur_row + 16'd1;
						if (cur_row >= row_hi_excl)
							cur_row = row_lo;
					end
				end
			end
		end
		res.disp = disp_flag;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cmd = CMD_NONE;
			param_cnt = '0;
			param_bytes[0] = '0;
			param_bytes[1] = '0;
			param_bytes[2] = '0;
			col_lo = '0;
			col_hi_excl = '0;
			row_lo = '0;
			row_hi_excl = '0;
			cur_col = '0;
			cur_row = '0;
			disp_flag = 1'b0;
			expected_writes.delete();
			results_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_write = {mem_write, mem_addr, mem_data, changed, out_of_range, display_on};
				if (expected_writes.size() == 0) begin
					report_mismatch("result transaction with no input waiting for it");
				end else begin
					due_write = expected_writes.pop_front();
					check_field("mem_write", 16'(seen_write.wr), 16'(due_write.wr));
					check_field("mem_addr", seen_write.addr, due_write.addr);
					check_field("mem_data", 16'(seen_write.data), 16'(due_write.data));
					check_field("changed", 16'(seen_write.chg), 16'(due_write.chg));
					check_field("out_of_range", 16'(seen_write.oor), 16'(due_write.oor));
					check_field("display_on", 16'(seen_write.disp), 16'(due_write.disp));
				end
			end
			if (in_valid && !in_stall)
				expected_writes.push_back(decode_spi_byte(data_byte, is_data, chip_select_n));
			results_due <= expected_writes.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// Testbench top that drives SPI byte transactions into the window writer and gives the verdict.
module tb_top
	import sdww_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RandomBytes = 1800;
	localparam int unsigned CycleLimit  = 400000;
	localparam logic DC_CMD  = 1'b0;
	localparam logic DC_DATA = 1'b1;
	localparam logic CS_ON   = 1'b0;
	localparam logic CS_OFF  = 1'b1;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        is_data = 1'b0;
	logic        chip_select_n = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        mem_write;
	logic [15:0] mem_addr;
	logic [7:0]  mem_data;
	logic        changed;
	logic        out_of_range;
	logic        display_on;
	int unsigned mismatch_count;
	int unsigned results_due;

	int unsigned cycle_count = 0;
	int unsigned stall_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned burst_left = 0;
	int unsigned sent_count = 0;

	spi_display_window_writer_top u_top (.*);

	frame_write_checker u_checker (.*);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("spi_display_window_writer_top test failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
			default:     out_stall <= (cycle_count % 5 < 2);
		endcase
	end

	task automatic send_byte(logic [7:0] b, logic dc, logic csn);
		int unsigned gap;
		data_byte <= b;
		is_data <= dc;
		chip_select_n <= csn;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (!csn)
			sent_count++;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
			                                         : $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	function automatic logic [7:0] other_command();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b[7:2] == 6'b001010 || b == OP_MEMWR)
			b = 8'h00;
		return b;
	endfunction

	task automatic set_window(logic [7:0] op, logic [15:0] lo, logic [15:0] hi);
		send_byte(op, DC_CMD, CS_ON);
		send_byte(lo[15:8], DC_DATA, CS_ON);
		send_byte(lo[7:0], DC_DATA, CS_ON);
		send_byte(hi[15:8], DC_DATA, CS_ON);
		send_byte(hi[7:0], DC_DATA, CS_ON);
	endtask

	task automatic write_pixels(int unsigned n);
		send_byte(OP_MEMWR, DC_CMD, CS_ON);
		repeat (n) send_byte(8'($urandom_range(0, 255)), DC_DATA, CS_ON);
	endtask

	task automatic random_window(logic [7:0] op, int unsigned span);
		logic [15:0] lo;
		logic [15:0] hi;
		lo = 16'($urandom_range(0, span));
		case ($urandom_range(0, 9))
			0: begin
				lo = 16'($urandom_range(0, 16'hFFFF));
				hi = 16'($urandom_range(0, 16'hFFFF));
			end
			1: hi = lo - 16'($urandom_range(1, 5));
			default: hi = lo + 16'($urandom_range(0, 7));
		endcase
		set_window(op, lo, hi);
	endtask

	task automatic broken_window();
		logic [7:0]  op;
		int unsigned given;
		op = $urandom_range(0, 1) ? OP_COLSET : OP_ROWSET;
		given = $urandom_range(0, 3);
		send_byte(op, DC_CMD, CS_ON);
		repeat (given) send_byte(8'($urandom_range(0, 255)), DC_DATA, CS_ON);
		if ($urandom_range(0, 1)) begin
			send_byte(other_command(), DC_CMD, CS_ON);
			repeat (4 - given) send_byte(8'($urandom_range(0, 180)), DC_DATA, CS_ON);
		end
	endtask

	initial begin
		int unsigned pick;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_byte(OP_COLSET, DC_CMD, CS_OFF);
		send_byte(8'hFF, DC_DATA, CS_ON);
		send_byte(8'hFF, DC_CMD, CS_ON);
		send_byte(OP_DISPON, DC_CMD, CS_ON);
		set_window(OP_COLSET, 16'hFFFF, 16'hFFFF);
		write_pixels(2);
		send_byte(OP_COLSET, DC_CMD, CS_ON);
		send_byte(8'h00, DC_DATA, CS_ON);
		send_byte(8'h00, DC_DATA, CS_ON);
		send_byte(8'h00, DC_CMD, CS_ON);
		send_byte(8'h00, DC_DATA, CS_ON);
		send_byte(8'h01, DC_DATA, CS_ON);
		send_byte(OP_ROWSET, DC_CMD, CS_ON);
		send_byte(8'h12, DC_DATA, CS_ON);
		set_window(OP_ROWSET, 16'd159, 16'd160);
		send_byte(OP_MEMWR, DC_CMD, CS_ON);
		send_byte(8'h00, DC_DATA, CS_ON);
		send_byte(8'hFF, DC_DATA, CS_ON);
		send_byte(8'hA5, DC_DATA, CS_ON);
		send_byte(8'h5A, DC_DATA, CS_ON);
		send_byte(8'hFF, DC_DATA, CS_ON);
		send_byte(8'h00, DC_DATA, CS_ON);

		sent_count = 0;
		while (sent_count < RandomBytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 18)
				random_window(OP_COLSET, 140);
			else if (pick < 36)
				random_window(OP_ROWSET, 175);
			else if (pick < 76)
				write_pixels($urandom_range(1, 24));
			else if (pick < 79)
				send_byte(OP_DISPON, DC_CMD, CS_ON);
			else if (pick < 82)
				send_byte(other_command(), DC_CMD, CS_ON);
			else if (pick < 92)
				broken_window();
			else
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				          ($urandom_range(0, 3) == 0) ? CS_OFF : CS_ON);
		end
		in_valid <= 1'b0;

		while (results_due != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (mismatch_count == 0)
			$display("spi_display_window_writer_top test passed");
		else
			$display("spi_display_window_writer_top test failed");
		$finish;
	end

endmodule
